// ===== sv/dpd_pkg.sv =====
// Shared types and constants for the double precision divider.
// Used by every module of the divider; depends on nothing.
package dpd_pkg;

   localparam int FRAC_W   = 52;
   localparam int MANT_W   = FRAC_W + 1;
   localparam int QUO_W    = MANT_W + 1;
   localparam int EXP_W    = 13;
   localparam int NUM_STEP = QUO_W;

   localparam logic [EXP_W-1:0] EXP_BIAS  = 13'd1022;
   localparam logic [11:0]      EXP_LIMIT = 12'd2047;

   typedef enum logic [1:0] {
      KIND_NORMAL  = 2'd0,
      KIND_DIVZERO = 2'd1,
      KIND_ZERO    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIVZERO  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // Payload of one division stage.
   typedef struct packed {
      logic                    sign;
      kind_type                kind;
      logic signed [EXP_W-1:0] expo;
      logic [QUO_W-1:0]        rem;
      logic [MANT_W-1:0]       den;
      logic [QUO_W-1:0]        quo;
   } stage_type;

endpackage

// ===== sv/double_precision_divider_top.sv =====
// Top level of the pipelined IEEE double divider.
// Instantiates dpd_prep, dpd_step, dpd_round; depends on dpd_pkg.

// The divider takes one request per clock unless the pipeline halts: one stage
// unpacks and pre-normalizes the mantissas, 54 stages each produce one quotient
// bit with a 54-bit compare and subtract, one stage adds the rounding addend and
// one stage aligns, packs and holds the result. The whole pipeline shifts
// together; it halts only while a result is held unaccepted and the stage
// before the result register is occupied, so a request is taken even while a
// result waits. Divisor zero and exponent overflow are reported in status; a
// zero dividend gives a zero quotient with status OK. NaN, infinity and
// subnormal inputs are treated as ordinary numbers with the hidden bit set.
module double_precision_divider_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // dividend [63:0], divisor [127:64]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata    // quotient [63:0], status [65:64], zero fill
);

   localparam int NUM_STEP = dpd_pkg::NUM_STEP;

   dpd_pkg::stage_type  pipe  [0:NUM_STEP];
   logic [NUM_STEP:0]   pipe_vld;
   logic                adv;
   logic [63:0]         quotient;
   logic [1:0]          status;

   assign req_tready = adv;

   dpd_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .valid_i  (req_tvalid),
      .dividend (req_tdata[63:0]),
      .divisor  (req_tdata[127:64]),
      .stage_ff (pipe[0]),
      .valid_ff (pipe_vld[0])
   );

   for (genvar i = 0; i < NUM_STEP; i++) begin : g_step
      dpd_step u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .valid_i  (pipe_vld[i]),
         .stage_i  (pipe[i]),
         .stage_ff (pipe[i+1]),
         .valid_ff (pipe_vld[i+1])
      );
   end

   dpd_round u_round (
      .clock        (clock),
      .reset        (reset),
      .valid_i      (pipe_vld[NUM_STEP]),
      .stage_i      (pipe[NUM_STEP]),
      .adv          (adv),
      .rsp_tready   (rsp_tready),
      .rsp_valid_ff (rsp_tvalid),
      .quotient_ff  (quotient),
      .status_ff    (status)
   );

   assign rsp_tdata = {6'd0, status, quotient};

`ifndef NO_ASSERTIONS
   // An empty result register never blocks new requests.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while the result register is empty");

   // A divide by zero always saturates the magnitude.
   a_divzero_pattern: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == dpd_pkg::STATUS_DIVZERO) |-> (quotient[62:0] == {63{1'b1}}))
      else $error("divide by zero result is not saturated");

   // Overflow always gives an infinity pattern.
   a_overflow_inf: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == dpd_pkg::STATUS_OVERFLOW)
      |-> (quotient[62:52] == 11'h7FF && quotient[51:0] == 52'd0))
      else $error("overflow result is not infinity");
`endif

endmodule

// ===== sv/dpd_prep.sv =====
// Operand unpacking, special case detection and mantissa pre-normalization.
// First register stage of the divider; depends on dpd_pkg.
module dpd_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 valid_i,
   input  logic [63:0]          dividend,
   input  logic [63:0]          divisor,
   output dpd_pkg::stage_type   stage_ff,
   output logic                 valid_ff
);

   dpd_pkg::stage_type stage_in;
   logic [dpd_pkg::MANT_W-1:0] mant_a;
   logic [dpd_pkg::MANT_W-1:0] mant_b;
   logic signed [dpd_pkg::EXP_W-1:0] expo_raw;

   always_comb begin
      mant_a   = {1'b1, dividend[dpd_pkg::FRAC_W-1:0]};
      mant_b   = {1'b1, divisor[dpd_pkg::FRAC_W-1:0]};
      expo_raw = $signed({2'b00, dividend[62:52]}) - $signed({2'b00, divisor[62:52]})
                 + $signed(dpd_pkg::EXP_BIAS);
      stage_in.sign = dividend[63] ^ divisor[63];
      stage_in.den  = mant_b;
      stage_in.quo  = '0;
      if (divisor[62:0] == 63'd0) begin
         stage_in.kind = dpd_pkg::KIND_DIVZERO;
      end else if (dividend[62:0] == 63'd0) begin
         stage_in.kind = dpd_pkg::KIND_ZERO;
      end else begin
         stage_in.kind = dpd_pkg::KIND_NORMAL;
      end
      // A dividend mantissa below the divisor mantissa is doubled so the
      // first quotient bit is always one.
      if (mant_a < mant_b) begin
         stage_in.rem  = {mant_a, 1'b0};
         stage_in.expo = expo_raw - 13'sd1;
      end else begin
         stage_in.rem  = {1'b0, mant_a};
         stage_in.expo = expo_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== sv/dpd_step.sv =====
// One restoring division step: compare, conditional subtract, shift.
// One register stage of the quotient pipeline; depends on dpd_pkg.
module dpd_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 valid_i,
   input  dpd_pkg::stage_type   stage_i,
   output dpd_pkg::stage_type   stage_ff,
   output logic                 valid_ff
);

   dpd_pkg::stage_type stage_in;
   logic [dpd_pkg::QUO_W-1:0] diff;
   logic                      take;

   always_comb begin
      stage_in = stage_i;
      diff     = stage_i.rem - {1'b0, stage_i.den};
      take     = stage_i.rem >= {1'b0, stage_i.den};
      // The remainder stays below the divisor after a step, so the
      // shifted value always fits.
      if (take) begin
         stage_in.rem = {diff[dpd_pkg::QUO_W-2:0], 1'b0};
      end else begin
         stage_in.rem = {stage_i.rem[dpd_pkg::QUO_W-2:0], 1'b0};
      end
      stage_in.quo = {stage_i.quo[dpd_pkg::QUO_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// ===== sv/dpd_round.sv =====
// Rounding, underflow alignment, packing and the result register.
// Last two stages of the divider and the pipeline stall control; depends on dpd_pkg.
module dpd_round (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_i,
   input  dpd_pkg::stage_type   stage_i,
   output logic                 adv,
   input  logic                 rsp_tready,
   output logic                 rsp_valid_ff,
   output logic [63:0]          quotient_ff,
   output logic [1:0]           status_ff
);

   logic                 vld_ff;
   logic                 sign_ff;
   dpd_pkg::kind_type    kind_ff;
   logic [63:0]          sum_ff;
   logic [5:0]           shamt_ff;
   logic                 zap_ff;
   logic [11:0]          expf_ff;

   logic [63:0]          sum_in;
   logic [5:0]           shamt_in;
   logic                 zap_in;
   logic [11:0]          expf_in;
   logic [dpd_pkg::EXP_W-1:0] neg;
   logic [63:0]          addend;

   logic                 out_take;
   logic [63:0]          shifted;
   logic [63:0]          quotient_in;
   logic [1:0]           status_in;

   // Shifting is allowed whenever the result register can load or the
   // rounding stage holds a bubble that may be overwritten.
   assign out_take = !rsp_valid_ff || rsp_tready;
   assign adv      = out_take || !vld_ff;

   always_comb begin
      neg = -stage_i.expo;
      if (stage_i.expo[dpd_pkg::EXP_W-1]) begin
         // Underflow: align the rounding addend to the subnormal position.
         addend   = (neg[dpd_pkg::EXP_W-1:6] != '0) ? 64'd0 : (64'd1 << neg[5:0]);
         shamt_in = neg[5:0] + 6'd1;
         zap_in   = neg >= 13'd63;
         expf_in  = 12'd0;
      end else begin
         addend   = 64'd1;
         shamt_in = 6'd1;
         zap_in   = 1'b0;
         expf_in  = stage_i.expo[11:0] + 12'd1;
      end
      sum_in = {{(64 - dpd_pkg::QUO_W){1'b0}}, stage_i.quo} + addend;
   end

   always_comb begin
      shifted = zap_ff ? 64'd0 : (sum_ff >> shamt_ff);
      unique case (kind_ff)
         dpd_pkg::KIND_DIVZERO: begin
            quotient_in = {sign_ff, {63{1'b1}}};
            status_in   = dpd_pkg::STATUS_DIVZERO;
         end
         dpd_pkg::KIND_ZERO: begin
            quotient_in = {sign_ff, 63'd0};
            status_in   = dpd_pkg::STATUS_OK;
         end
         dpd_pkg::KIND_NORMAL: begin
            if (expf_ff >= dpd_pkg::EXP_LIMIT) begin
               quotient_in = {sign_ff, 11'h7FF, 52'd0};
               status_in   = dpd_pkg::STATUS_OVERFLOW;
            end else begin
               // A rounding carry past the hidden bit lands in the exponent.
               quotient_in = {sign_ff, 63'd0} | {1'b0, expf_ff[10:0], 52'd0}
                             | (shifted & ~(64'd1 << dpd_pkg::FRAC_W));
               status_in   = dpd_pkg::STATUS_OK;
            end
         end
         default: begin
            quotient_in = '0;
            status_in   = dpd_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= valid_i;
         end
         if (out_take) begin
            rsp_valid_ff <= vld_ff;
         end
      end
      if (adv) begin
         sign_ff  <= stage_i.sign;
         kind_ff  <= stage_i.kind;
         sum_ff   <= sum_in;
         shamt_ff <= shamt_in;
         zap_ff   <= zap_in;
         expf_ff  <= expf_in;
      end
      if (out_take) begin
         quotient_ff <= quotient_in;
         status_ff   <= status_in;
      end
   end

endmodule
